// ----- rtl/core/fractal_value_noise_2d_top_assert.svh -----
// Assertion macros for the fractal value noise block.
// Used by fractal_value_noise_2d_top; expects clk_i and rst_ni in scope.
`ifndef FRACTAL_VALUE_NOISE_2D_TOP_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_2D_TOP_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define FVN_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("fvn: invariant violated");

// Whenever the cause is seen, the effect holds in the same cycle.
`define FVN_ASSERT_IMPLY(name, cause, effect) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |-> (effect)) \
    else $error("fvn: implication violated");

// Whenever the cause is seen, the effect holds in the next cycle.
`define FVN_ASSERT_NEXT(name, cause, effect) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error("fvn: expected follow-up missing");

`endif

// ----- rtl/core/fvn_pkg.sv -----
// Shared constants, types and the quintic fade table of the fractal value noise block.
// No dependencies; every other file of the block but the assertion macro header uses it by scoped names.
`default_nettype none

package fvn_pkg;

  localparam int unsigned DATA_W        = 16;
  localparam int unsigned INDEX_W       = 16;
  localparam int unsigned POS_IN_W      = 16;
  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned FRAC_STEPS    = 1 << FRACTION_BITS;
  localparam int unsigned FADE_FRAC     = 16;
  localparam int unsigned FADE_W        = FADE_FRAC + 1;
  localparam int unsigned GRID_SIZE_DEF = 256;
  localparam int unsigned OCTAVES_DEF   = 4;
  localparam int unsigned BANKS         = 4;
  // Must stay a power of two: the result buffer pointers wrap naturally.
  localparam int unsigned RESULT_DEPTH  = 4;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef logic [FADE_W-1:0] fade_t;
  typedef fade_t fade_lut_t [FRAC_STEPS];

  // Fade weight 6w^5 - 15w^4 + 10w^3 in Q1.16, rounded half up.
  function automatic fade_lut_t build_fade_lut();
    fade_lut_t       lut;
    longint unsigned ff;
    longint unsigned one;
    longint unsigned q;
    longint unsigned num;
    int unsigned     sh;
    one = 64'd1 << FRACTION_BITS;
    sh  = 5 * FRACTION_BITS - FADE_FRAC;
    for (int unsigned f = 0; f < FRAC_STEPS; f++) begin
      ff     = longint'(f);
      q      = 6 * ff * ff + 10 * one * one - 15 * ff * one;
      num    = ff * ff * ff * q;
      lut[f] = FADE_W'((num + (64'd1 << (sh - 1))) >> sh);
    end
    return lut;
  endfunction

  localparam fade_lut_t FADE_LUT = build_fade_lut();

  // Per-octave tag that travels with the lattice reads.
  typedef struct packed {
    logic  first;
    logic  last;
    logic  row_odd;
    logic  col_odd;
    fade_t wx;
    fade_t wy;
  } octave_tag_t;

  // Status of the read sequencer as seen by the top level.
  typedef struct packed {
    logic can_take;
    logic busy;
  } issue_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/fvn_if.sv -----
// Valid/ready channel interfaces for commands and noise results.
// Depends on fvn_pkg for the field widths.
`default_nettype none

interface fvn_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [fvn_pkg::INDEX_W-1:0]         entry_index;
  logic signed [fvn_pkg::DATA_W-1:0]   entry_value;
  logic [fvn_pkg::POS_IN_W-1:0]        pos_x;
  logic [fvn_pkg::POS_IN_W-1:0]        pos_y;

  modport source (
    output valid, command, entry_index, entry_value, pos_x, pos_y,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_value, pos_x, pos_y,
    output ready
  );
endinterface

interface fvn_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [fvn_pkg::DATA_W-1:0]   noise_value;

  modport source (
    output valid, noise_value,
    input  ready
  );
  modport sink (
    input  valid, noise_value,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/fractal_value_noise_2d_top.sv -----
// Top level of the fractal value noise block; depends on fvn_pkg, fvn_if, fvn_ram,
// fvn_issue, fvn_octave_blend, fvn_result_buf and the assertion macro header.
//
// Usage. Commands arrive on cmd_i and noise results leave on res_o, both valid/ready
// channels; a transfer happens at a rising edge where valid and ready are high.
// A write command stores entry_value at entry_index (row times the grid size plus
// column) and produces no result. A sample command produces exactly one noise_value.
// The lattice lives in four RAM banks split by row and column parity, so the four
// corners of one cell are read in the same cycle. A sample occupies the read
// sequencer while it steps through its OCTAVES octaves (4 by default), and a new
// command is taken as soon as the sequencer frees up. A result reaches res_o
// through three blend stages, the octave accumulator and the result queue. A
// stalled receiver fills a four-entry result queue; cmd_i.ready drops once four
// samples are pending. Reset clears all control state but not the lattice, whose
// entries are undefined until loaded; no clearing pass runs and commands are
// taken right after reset.
`default_nettype none

`include "fractal_value_noise_2d_top_assert.svh"

module fractal_value_noise_2d_top #(
  parameter int unsigned GRID_SIZE = fvn_pkg::GRID_SIZE_DEF,
  parameter int unsigned OCTAVES   = fvn_pkg::OCTAVES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fvn_cmd_if.sink   cmd_i,
  fvn_res_if.source res_o
);

  localparam int unsigned GRID_BITS  = $clog2(GRID_SIZE);
  localparam int unsigned BANK_AW    = 2 * GRID_BITS - 2;
  localparam int unsigned BANK_DEPTH = GRID_SIZE * GRID_SIZE / fvn_pkg::BANKS;
  localparam int unsigned PEND_W     = $clog2(fvn_pkg::RESULT_DEPTH + 1);

  // Handshakes and the pending-sample count that guards the result queue.
  logic                              cmd_xfer;
  logic                              res_xfer;
  logic                              sample_take;
  logic [PEND_W-1:0]                 pending_q, pending_d;

  fvn_pkg::issue_status_t            issue_status;
  logic [fvn_pkg::BANKS-1:0]         bank_we;
  logic [BANK_AW-1:0]                bank_waddr;
  logic [fvn_pkg::DATA_W-1:0]        bank_wdata;
  logic [BANK_AW-1:0]                bank_raddr [fvn_pkg::BANKS];
  logic signed [fvn_pkg::DATA_W-1:0] bank_rdata [fvn_pkg::BANKS];
  logic                              tag_valid;
  fvn_pkg::octave_tag_t              tag;
  logic                              res_push;
  logic signed [fvn_pkg::DATA_W-1:0] res_value;

  assign cmd_i.ready = issue_status.can_take && (pending_q < PEND_W'(fvn_pkg::RESULT_DEPTH));
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;
  assign res_xfer    = res_o.valid && res_o.ready;
  assign sample_take = cmd_xfer && (cmd_i.command == fvn_pkg::CMD_SAMPLE);
  assign pending_d   = pending_q + PEND_W'(sample_take) - PEND_W'(res_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // Command intake, table writes and per-octave read addresses.
  fvn_issue #(
    .GRID_SIZE (GRID_SIZE),
    .OCTAVES   (OCTAVES)
  ) u_issue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (cmd_xfer),
    .command_i     (cmd_i.command),
    .entry_index_i (cmd_i.entry_index),
    .entry_value_i (cmd_i.entry_value),
    .pos_x_i       (cmd_i.pos_x),
    .pos_y_i       (cmd_i.pos_y),
    .status_o      (issue_status),
    .we_o          (bank_we),
    .waddr_o       (bank_waddr),
    .wdata_o       (bank_wdata),
    .raddr_o       (bank_raddr),
    .tag_valid_o   (tag_valid),
    .tag_o         (tag)
  );

  // Lattice storage, one bank per (row parity, column parity) pair.
  for (genvar b = 0; b < fvn_pkg::BANKS; b++) begin : g_lattice
    fvn_ram #(
      .WIDTH (fvn_pkg::DATA_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (bank_waddr),
      .wdata_i (bank_wdata),
      .raddr_i (bank_raddr[b]),
      .rdata_o (bank_rdata[b])
    );
  end

  // Fade blends and the weighted octave sum.
  fvn_octave_blend #(
    .OCTAVES (OCTAVES)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_valid_i (tag_valid),
    .tag_i       (tag),
    .rdata_i     (bank_rdata),
    .res_valid_o (res_push),
    .res_o       (res_value)
  );

  // Results wait here while the receiver stalls; the pending count keeps it from overflowing.
  fvn_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_value),
    .pop_i       (res_o.ready),
    .valid_o     (res_o.valid),
    .data_o      (res_o.noise_value)
  );

  // The pending count never exceeds the queue depth.
  `FVN_ASSERT_ALWAYS(a_pending_bound, pending_q <= PEND_W'(fvn_pkg::RESULT_DEPTH))
  // A result on the output always belongs to a sample counted as pending.
  `FVN_ASSERT_IMPLY(a_result_pending, res_o.valid, pending_q != '0)
  // Every command transfer puts the sequencer to work in the following cycle.
  `FVN_ASSERT_NEXT(a_take_starts_issue, cmd_xfer, issue_status.busy)

endmodule

`default_nettype wire

// ----- rtl/core/fvn_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on fvn_pkg for the default width.
`default_nettype none

module fvn_ram #(
  parameter int unsigned WIDTH = fvn_pkg::DATA_W,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/fvn_issue.sv -----
// Read sequencer: takes commands, writes table entries and issues four banked
// lattice reads per octave. Depends on fvn_pkg.
`default_nettype none

module fvn_issue #(
  parameter int unsigned GRID_SIZE = fvn_pkg::GRID_SIZE_DEF,
  parameter int unsigned OCTAVES   = fvn_pkg::OCTAVES_DEF,
  localparam int unsigned GRID_BITS = $clog2(GRID_SIZE),
  localparam int unsigned BANK_AW   = 2 * GRID_BITS - 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  logic                              command_i,
  input  logic [fvn_pkg::INDEX_W-1:0]       entry_index_i,
  input  logic [fvn_pkg::DATA_W-1:0]        entry_value_i,
  input  logic [fvn_pkg::POS_IN_W-1:0]      pos_x_i,
  input  logic [fvn_pkg::POS_IN_W-1:0]      pos_y_i,
  output fvn_pkg::issue_status_t            status_o,
  output logic [fvn_pkg::BANKS-1:0]         we_o,
  output logic [BANK_AW-1:0]                waddr_o,
  output logic [fvn_pkg::DATA_W-1:0]        wdata_o,
  output logic [BANK_AW-1:0]                raddr_o [fvn_pkg::BANKS],
  output logic                              tag_valid_o,
  output fvn_pkg::octave_tag_t              tag_o
);

  localparam int unsigned FB       = fvn_pkg::FRACTION_BITS;
  localparam int unsigned IDX_W    = 2 * GRID_BITS;
  localparam int unsigned PW       = GRID_BITS + FB;
  localparam int unsigned OCT_W    = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
  localparam logic [OCT_W-1:0] LAST_OCT = OCT_W'(OCTAVES - 1);

  typedef enum logic [2:0] {
    IS_IDLE   = 3'b001,
    IS_WRITE  = 3'b010,
    IS_SAMPLE = 3'b100
  } issue_state_e;

  issue_state_e              state_q, state_d;
  logic [OCT_W-1:0]          oct_q, oct_d;
  logic [PW-1:0]             px_q, px_d, py_q, py_d;
  logic [IDX_W-1:0]          widx_q;
  logic [fvn_pkg::DATA_W-1:0] wval_q;
  logic                      free;
  logic                      tag_valid_q;
  fvn_pkg::octave_tag_t      tag_q;

  logic [GRID_BITS-1:0] ix, iy, ix1, iy1;
  logic [GRID_BITS-1:0] wrow, wcol;

  always_comb begin
    state_d = state_q;
    oct_d   = oct_q;
    px_d    = px_q;
    py_d    = py_q;
    case (state_q)
      IS_IDLE:   free = 1'b1;
      IS_WRITE:  free = 1'b1;
      IS_SAMPLE: free = (oct_q == LAST_OCT);
      default:   free = 1'b1;
    endcase
    if (state_q == IS_SAMPLE) begin
      // Next octave: both positions double, wrapping at the grid span.
      px_d  = px_q << 1;
      py_d  = py_q << 1;
      oct_d = oct_q + OCT_W'(1);
    end
    if (free) begin
      state_d = IS_IDLE;
    end
    if (take_i) begin
      state_d = (command_i == fvn_pkg::CMD_SAMPLE) ? IS_SAMPLE : IS_WRITE;
      oct_d   = '0;
      px_d    = PW'(pos_x_i);
      py_d    = PW'(pos_y_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IS_IDLE;
      oct_q       <= '0;
      tag_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oct_q       <= oct_d;
      tag_valid_q <= (state_q == IS_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    if (take_i) begin
      widx_q <= IDX_W'(entry_index_i);
      wval_q <= entry_value_i;
    end
    tag_q.first   <= (oct_q == '0);
    tag_q.last    <= (oct_q == LAST_OCT);
    tag_q.row_odd <= ix[0];
    tag_q.col_odd <= iy[0];
    tag_q.wx      <= fvn_pkg::FADE_LUT[px_q[FB-1:0]];
    tag_q.wy      <= fvn_pkg::FADE_LUT[py_q[FB-1:0]];
  end

  // Table write: the parity of row and column picks the bank.
  assign wrow    = widx_q[IDX_W-1:GRID_BITS];
  assign wcol    = widx_q[GRID_BITS-1:0];
  assign waddr_o = {wrow[GRID_BITS-1:1], wcol[GRID_BITS-1:1]};
  assign wdata_o = wval_q;

  assign ix  = px_q[PW-1:FB];
  assign iy  = py_q[PW-1:FB];
  assign ix1 = ix + GRID_BITS'(1);
  assign iy1 = iy + GRID_BITS'(1);

  // The four corners of a lattice cell always fall in four different banks.
  for (genvar b = 0; b < fvn_pkg::BANKS; b++) begin : g_bank
    localparam logic ROW_ODD = 1'(b / 2);
    localparam logic COL_ODD = 1'(b % 2);
    logic [GRID_BITS-1:0] row_sel, col_sel;
    assign row_sel    = (ix[0] == ROW_ODD) ? ix : ix1;
    assign col_sel    = (iy[0] == COL_ODD) ? iy : iy1;
    assign raddr_o[b] = {row_sel[GRID_BITS-1:1], col_sel[GRID_BITS-1:1]};
    assign we_o[b]    = (state_q == IS_WRITE) && (wrow[0] == ROW_ODD) && (wcol[0] == COL_ODD);
  end

  assign status_o.can_take = free;
  assign status_o.busy     = (state_q != IS_IDLE);
  assign tag_valid_o       = tag_valid_q;
  assign tag_o             = tag_q;

endmodule

`default_nettype wire

// ----- rtl/core/fvn_octave_blend.sv -----
// Blend and accumulate pipeline: three fade blends per octave and the weighted
// octave sum with final rounding. Depends on fvn_pkg.
`default_nettype none

module fvn_octave_blend #(
  parameter int unsigned OCTAVES = fvn_pkg::OCTAVES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              tag_valid_i,
  input  fvn_pkg::octave_tag_t              tag_i,
  input  logic signed [fvn_pkg::DATA_W-1:0] rdata_i [fvn_pkg::BANKS],
  output logic                              res_valid_o,
  output logic signed [fvn_pkg::DATA_W-1:0] res_o
);

  localparam int unsigned DW     = fvn_pkg::DATA_W;
  localparam int unsigned PROD_W = (DW + 1) + (fvn_pkg::FADE_W + 1);
  localparam int unsigned ACC_W  = DW + OCTAVES + 1;
  localparam logic signed [PROD_W-1:0] BLEND_HALF = PROD_W'(1) << (fvn_pkg::FADE_FRAC - 1);
  localparam logic signed [ACC_W-1:0]  SUM_HALF   = ACC_W'(1) << (OCTAVES - 1);

  logic signed [DW-1:0]     a00, a01, a10, a11;
  logic signed [DW:0]       d0, d1, d2;
  logic signed [PROD_W-1:0] t0, t1, t2;
  logic signed [DW-1:0]     v;
  logic signed [ACC_W-1:0]  acc_d, rnd;

  logic                     s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q;
  logic                     s0_first_q, s1_first_q, s2_first_q;
  logic                     s0_last_q, s1_last_q, s2_last_q, s3_last_q;
  logic signed [DW-1:0]     s0_a00_q, s0_a10_q;
  logic signed [PROD_W-1:0] s0_p0_q, s0_p1_q;
  fvn_pkg::fade_t           s0_wx_q, s1_wx_q;
  logic signed [DW-1:0]     s1_r0_q, s1_r1_q;
  logic signed [DW-1:0]     s2_r0_q;
  logic signed [PROD_W-1:0] s2_p_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Corner routing: the parity of the lower corner tells which bank holds which corner.
  assign a00 = rdata_i[{tag_i.row_odd, tag_i.col_odd}];
  assign a01 = rdata_i[{tag_i.row_odd, ~tag_i.col_odd}];
  assign a10 = rdata_i[{~tag_i.row_odd, tag_i.col_odd}];
  assign a11 = rdata_i[{~tag_i.row_odd, ~tag_i.col_odd}];

  assign d0 = {a01[DW-1], a01} - {a00[DW-1], a00};
  assign d1 = {a11[DW-1], a11} - {a10[DW-1], a10};
  assign t0 = (s0_p0_q + BLEND_HALF) >>> fvn_pkg::FADE_FRAC;
  assign t1 = (s0_p1_q + BLEND_HALF) >>> fvn_pkg::FADE_FRAC;
  assign d2 = {s1_r1_q[DW-1], s1_r1_q} - {s1_r0_q[DW-1], s1_r0_q};
  assign t2 = (s2_p_q + BLEND_HALF) >>> fvn_pkg::FADE_FRAC;

  // The blend result always lies between its two ends, so 16 bits hold it.
  assign v     = s2_r0_q + t2[DW-1:0];
  assign acc_d = s2_first_q ? ACC_W'(v) : (acc_q <<< 1) + ACC_W'(v);
  assign rnd   = (acc_q + SUM_HALF) >>> OCTAVES;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= tag_valid_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_first_q <= tag_i.first;
    s0_last_q  <= tag_i.last;
    s0_a00_q   <= a00;
    s0_a10_q   <= a10;
    s0_p0_q    <= d0 * $signed({1'b0, tag_i.wy});
    s0_p1_q    <= d1 * $signed({1'b0, tag_i.wy});
    s0_wx_q    <= tag_i.wx;

    s1_first_q <= s0_first_q;
    s1_last_q  <= s0_last_q;
    s1_r0_q    <= s0_a00_q + t0[DW-1:0];
    s1_r1_q    <= s0_a10_q + t1[DW-1:0];
    s1_wx_q    <= s0_wx_q;

    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_r0_q    <= s1_r0_q;
    s2_p_q     <= d2 * $signed({1'b0, s1_wx_q});

    s3_last_q  <= s2_last_q;
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
  end

  assign res_valid_o = s3_vld_q && s3_last_q;
  assign res_o       = rnd[DW-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/fvn_result_buf.sv -----
// Small result queue between the blend pipeline and the output channel.
// Depends on fvn_pkg for its depth and data width.
`default_nettype none

module fvn_result_buf (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic signed [fvn_pkg::DATA_W-1:0] push_data_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output logic signed [fvn_pkg::DATA_W-1:0] data_o
);

  localparam int unsigned PTR_W = $clog2(fvn_pkg::RESULT_DEPTH);
  localparam int unsigned CNT_W = $clog2(fvn_pkg::RESULT_DEPTH + 1);

  logic signed [fvn_pkg::DATA_W-1:0] slot_q [fvn_pkg::RESULT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop   = pop_i && valid_o;
  assign wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
  assign rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
  assign count_d  = count_q + CNT_W'(push_i) - CNT_W'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- sim/fractal_value_noise_2d_top_test.sv -----
// Self-checking testbench for fractal_value_noise_2d_top: lattice loads, noise samples,
// a local noise predictor and in-order result checking. Needs fvn_pkg, fvn_if and the RTL.
`timescale 1ns / 100ps

module fractal_value_noise_2d_top_test;

  // Four octaves as built by default; the lattice is 256 x 256, so a row or a column
  // index is exactly one byte and wraps on its own.
  localparam int unsigned NOISE_OCTAVES = fvn_pkg::OCTAVES_DEF;
  // Number of random transfers after the directed part.
  localparam int unsigned RANDOM_ITEMS  = 1300;
  // Once fewer commands than this are left, neither side idles any more.
  localparam int unsigned QUIET_TAIL    = 150;
  // Length of the single long receiver hold-off, in cycles.
  localparam int unsigned LONG_HOLD     = 200;

  // One command as it waits in the driver queue. The drain flag makes the driver
  // wait until every expected noise value has come back before offering it.
  typedef struct {
    fvn_pkg::cmd_e      command;
    logic [15:0]        entry_index;
    logic signed [15:0] entry_value;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    bit                 drain_first;
  } noise_cmd_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fvn_cmd_if cmd_ch ();
  fvn_res_if res_ch ();

  fractal_value_noise_2d_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch.sink),
    .res_o  (res_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // Commands still to be transferred, and noise values still to be returned.
  noise_cmd_t         pending_cmds[$];
  logic signed [15:0] expected_noise[$];

  // The lattice as the block should hold it, updated at each accepted write.
  logic signed [15:0] lattice_mirror [0:65535];
  // Entries that the stimulus has loaded so far. Samples are only built on top of
  // loaded entries, since reading a never-written entry is not defined.
  bit                 lattice_loaded [0:65535];
  // Positions already sampled; reused to hit cells that are loaded already.
  logic [31:0]        visited_pos[$];
  bit                 drain_next = 1'b0;

  int unsigned error_count        = 0;
  int unsigned noise_results_seen = 0;
  bit          cmd_offered        = 1'b0;

  // ---------------------------------------------------------------------------
  // Noise predictor
  // ---------------------------------------------------------------------------

  // Quintic fade 6w^5 - 15w^4 + 10w^3 of an 8-bit fraction in Q1.16 (0..65536),
  // computed exactly and rounded half up.
  function automatic longint fade_q16(input logic [7:0] frac);
    longint f;
    longint q;
    f = longint'(frac);
    q = 6 * f * f + 10 * 65536 - 15 * f * 256;
    return (f * f * f * q + (64'sd1 <<< 23)) >>> 24;
  endfunction

  // Blend from a toward b by a Q1.16 weight; the arithmetic shift is a floor, which
  // keeps the result between the two end points.
  function automatic longint blend_q16(input longint a, input longint b, input longint w);
    return a + (((b - a) * w + 32768) >>> 16);
  endfunction

  // Row follows the x lattice coordinate, column the y coordinate.
  function automatic longint lattice_at(input logic [7:0] row, input logic [7:0] col);
    return longint'(lattice_mirror[{row, col}]);
  endfunction

  // Sum of four octaves, octave i weighted 2^-(i+1). Octave values are summed at
  // full precision scaled by 16, then rounded half up back to Q1.15.
  function automatic logic signed [15:0] predict_noise(input logic [15:0] px,
                                                       input logic [15:0] py);
    longint      acc;
    longint      wx;
    longint      wy;
    longint      row_lo;
    longint      row_hi;
    longint      oct_val;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [7:0]  ix;
    logic [7:0]  iy;
    acc = 0;
    ox  = px;
    oy  = py;
    for (int o = 0; o < NOISE_OCTAVES; o++) begin
      ix      = ox[15:8];
      iy      = oy[15:8];
      wx      = fade_q16(ox[7:0]);
      wy      = fade_q16(oy[7:0]);
      // The y fraction blends along each row first, then x blends the two rows.
      // Adding one to a byte index wraps the lattice edge back to zero.
      row_lo  = blend_q16(lattice_at(ix, iy), lattice_at(ix, iy + 8'd1), wy);
      row_hi  = blend_q16(lattice_at(ix + 8'd1, iy), lattice_at(ix + 8'd1, iy + 8'd1), wy);
      oct_val = blend_q16(row_lo, row_hi, wx);
      acc    += oct_val <<< (NOISE_OCTAVES - 1 - o);
      // Doubling a 16-bit position is the wrap modulo the grid span.
      ox      = ox << 1;
      oy      = oy << 1;
    end
    return 16'((acc + (64'sd1 <<< (NOISE_OCTAVES - 1))) >>> NOISE_OCTAVES);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  // Lattice values lean toward the extremes now and then.
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // A write leaves the position fields unused, so they carry random junk.
  task automatic push_write(input logic [15:0] idx, input logic signed [15:0] val);
    noise_cmd_t c;
    c.command     = fvn_pkg::CMD_WRITE;
    c.entry_index = idx;
    c.entry_value = val;
    c.pos_x       = 16'($urandom);
    c.pos_y       = 16'($urandom);
    c.drain_first = drain_next;
    drain_next    = 1'b0;
    lattice_loaded[idx] = 1'b1;
    pending_cmds.push_back(c);
  endtask

  // A sample is preceded by writes for every cell of its four octaves that has not
  // been loaded yet, so no sample ever touches an undefined entry.
  task automatic push_sample(input logic [15:0] px, input logic [15:0] py);
    noise_cmd_t  c;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [7:0]  row;
    logic [7:0]  col;
    ox = px;
    oy = py;
    for (int o = 0; o < NOISE_OCTAVES; o++) begin
      for (int corner = 0; corner < 4; corner++) begin
        row = ox[15:8] + 8'(corner >> 1);
        col = oy[15:8] + 8'(corner & 1);
        if (!lattice_loaded[{row, col}]) begin
          push_write({row, col}, pick_value());
        end
      end
      ox = ox << 1;
      oy = oy << 1;
    end
    c.command     = fvn_pkg::CMD_SAMPLE;
    c.entry_index = 16'($urandom);
    c.entry_value = 16'($urandom);
    c.pos_x       = px;
    c.pos_y       = py;
    c.drain_first = drain_next;
    drain_next    = 1'b0;
    visited_pos.push_back({px, py});
    pending_cmds.push_back(c);
  endtask

  // Builds the whole command stream up front: a short directed part, then random
  // traffic that is mostly well-formed load-and-sample sequences.
  task automatic build_stimulus();
    logic [31:0] prev;
    logic [15:0] px;
    logic [15:0] py;
    int unsigned target;
    int unsigned next_drain;

    // Extreme values at the origin cell; with all fractions zero every octave sees
    // the top-left corner only, so this gives the largest positive output.
    push_write(16'h0000, 16'sh7FFF);
    push_write(16'h0001, 16'sh8000);
    push_write(16'h0100, 16'sh8000);
    push_write(16'h0101, 16'sh7FFF);
    push_sample(16'h0000, 16'h0000);
    // Lattice edge on both axes: an all-ones position sits on row and column 255
    // in every octave, and its neighbors wrap to row and column 0.
    push_write(16'hFFFF, 16'sh8000);
    push_write(16'hFF00, 16'sh7FFF);
    push_write(16'h00FF, 16'sh7FFF);
    push_sample(16'hFFFF, 16'hFFFF);
    // Edge on one axis only, in each direction.
    push_sample(16'h0000, 16'hFFFF);
    push_sample(16'hFFFF, 16'h0000);
    // A write right behind a sample must be seen by the next sample.
    push_write(16'hFFFF, 16'sh7FFF);
    push_sample(16'hFFFF, 16'hFFFF);
    push_sample(16'h8000, 16'h7FFF);

    // The first random command waits for the directed results to drain, and one
    // more drain point sits in the middle of the random part.
    drain_next = 1'b1;
    target     = pending_cmds.size() + RANDOM_ITEMS;
    next_drain = pending_cmds.size() + RANDOM_ITEMS / 2;
    while (pending_cmds.size() < target) begin
      if (pending_cmds.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain = target + 1;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          // Fresh position, loading whatever it needs; sometimes pinned to the edge.
          px = 16'($urandom);
          py = 16'($urandom);
          if ($urandom_range(0, 7) == 0) px[15:8] = 8'hFF;
          if ($urandom_range(0, 7) == 0) py[15:8] = 8'hFF;
          push_sample(px, py);
        end
        4, 5: begin
          // Stray write anywhere in the table.
          push_write(16'($urandom), pick_value());
        end
        6, 7: begin
          // Overwrite a cell that an earlier sample used, then sample it again.
          prev = visited_pos[$urandom_range(0, visited_pos.size() - 1)];
          push_write({prev[31:24], prev[15:8]}, pick_value());
          push_sample(prev[31:16], prev[15:0]);
        end
        default: begin
          // Revisit a loaded area. The low five bits of a position change only the
          // fractions, never the lattice cells of any octave.
          prev = visited_pos[$urandom_range(0, visited_pos.size() - 1)];
          push_sample({prev[31:21], 5'($urandom)}, {prev[15:5], 5'($urandom)});
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: changes its outputs at the falling edge only.
  // ---------------------------------------------------------------------------

  int unsigned tx_gap_left   = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned tx_phase_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      // The idle rate is redrawn at the start of each phase, so some stretches run flat out.
      if (tx_phase_left == 0) begin
        tx_idle_pct   = 25 * $urandom_range(0, 2);
        tx_phase_left = 100;
      end else begin
        tx_phase_left--;
      end
      if (cmd_offered) begin
        // A command once offered stays on the bus until its transfer.
      end else if (tx_gap_left != 0) begin
        tx_gap_left--;
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds[0].drain_first && expected_noise.size() != 0) begin
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() >= QUIET_TAIL &&
                   $urandom_range(0, 99) < tx_idle_pct) begin
        // This cycle counts as the first one of an idle burst.
        tx_gap_left  = $urandom_range(0, 16);
        cmd_ch.valid <= 1'b0;
      end else begin
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= pending_cmds[0].command;
        cmd_ch.entry_index <= pending_cmds[0].entry_index;
        cmd_ch.entry_value <= pending_cmds[0].entry_value;
        cmd_ch.pos_x       <= pending_cmds[0].pos_x;
        cmd_ch.pos_y       <= pending_cmds[0].pos_y;
        cmd_offered        = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command monitor: each accepted transfer updates the mirror or queues the
  // noise value that the block has to return for it.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    noise_cmd_t taken;
    if (rst_ni && cmd_ch.valid && cmd_ch.ready) begin
      taken       = pending_cmds.pop_front();
      cmd_offered = 1'b0;
      if (taken.command == fvn_pkg::CMD_WRITE) begin
        lattice_mirror[taken.entry_index] = taken.entry_value;
      end else begin
        expected_noise.push_back(predict_noise(taken.pos_x, taken.pos_y));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off early in the run that
  // lets the result queue fill up and back-pressure the command side.
  // ---------------------------------------------------------------------------

  int unsigned rx_stall_left  = 0;
  int unsigned rx_hold_left   = 0;
  int unsigned rx_idle_pct    = 0;
  int unsigned rx_phase_left  = 0;
  bit          long_hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_idle_pct   = 25 * $urandom_range(0, 2);
        rx_phase_left = 100;
      end else begin
        rx_phase_left--;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!long_hold_done && noise_results_seen >= 40) begin
        long_hold_done = 1'b1;
        rx_hold_left   = LONG_HOLD - 1;
        res_ch.ready   <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left--;
        res_ch.ready <= 1'b0;
      end else if (pending_cmds.size() >= QUIET_TAIL &&
                   $urandom_range(0, 99) < rx_idle_pct) begin
        rx_stall_left = $urandom_range(0, 16);
        res_ch.ready  <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: results come back in command order, so each one is matched
  // against the oldest outstanding prediction.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    logic signed [15:0] want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      noise_results_seen++;
      if (expected_noise.size() == 0) begin
        $display("%0t: unexpected noise_value transfer, actual %0d, nothing expected",
                 $time, res_ch.noise_value);
        error_count++;
      end else begin
        want = expected_noise.pop_front();
        if (res_ch.noise_value !== want) begin
          $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                   $time, want, res_ch.noise_value);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------

  initial begin
    cmd_ch.valid       = 1'b0;
    cmd_ch.command     = fvn_pkg::CMD_WRITE;
    cmd_ch.entry_index = '0;
    cmd_ch.entry_value = '0;
    cmd_ch.pos_x       = '0;
    cmd_ch.pos_y       = '0;
    res_ch.ready       = 1'b0;
    build_stimulus();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Wait for every command to be transferred and every noise value to return,
    // then give the pipeline time to show any stray result.
    wait (pending_cmds.size() == 0);
    wait (expected_noise.size() == 0);
    repeat (4 * (NOISE_OCTAVES + 5)) @(posedge clk_i);
    if (error_count == 0 && expected_noise.size() == 0) begin
      $display("[fractal_value_noise_2d_top] OK");
    end else begin
      $display("[fractal_value_noise_2d_top] ERROR");
    end
    $finish;
  end

  // The timeout lies well beyond what a correct run needs even with every stall at its longest.
  initial begin
    #8ms;
    $display("%0t: timeout, %0d commands and %0d results outstanding",
             $time, pending_cmds.size(), expected_noise.size());
    $display("[fractal_value_noise_2d_top] ERROR");
    $finish;
  end

endmodule

// ----- fractal_value_noise_2d_top.f -----
+incdir+rtl/core
rtl/core/fvn_pkg.sv
rtl/core/fvn_if.sv
rtl/core/fvn_ram.sv
rtl/core/fvn_issue.sv
rtl/core/fvn_octave_blend.sv
rtl/core/fvn_result_buf.sv
rtl/core/fractal_value_noise_2d_top.sv
sim/fractal_value_noise_2d_top_test.sv
